[hw/rtl/marching_tetrahedra_cube_top_macros.svh]
// Assertion macros shared by the marching tetrahedra block.
`ifndef MARCHING_TETRAHEDRA_CUBE_TOP_MACROS_SVH
`define MARCHING_TETRAHEDRA_CUBE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication.
`define MTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MTC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MTC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/mtc_pkg.sv]
`timescale 1ns / 1ps
package mtc_pkg;

  localparam int NUM_TETRA = 5;
  localparam int NUM_SLOT  = 4;

  // Lane sequencer steps.
  typedef logic [3:0] step_t;
  localparam step_t STEP_CASE      = 4'd0;
  localparam step_t STEP_MUL       = 4'd1;
  localparam step_t STEP_DIV_FIRST = 4'd2;
  localparam step_t STEP_DIV_LAST  = 4'd9;
  localparam step_t STEP_FIN       = 4'd10;
  localparam step_t STEP_DONE      = 4'd11;

  // Register indexes and reset values.
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_VOXEL_SIZE = 1'b1;
  localparam logic [15:0] THRESHOLD_RESET  = 16'd32768;
  localparam logic [15:0] VOXEL_SIZE_RESET = 16'd256;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
  } vert_t;

  typedef struct packed {
    logic ld_case;
    logic ld_mul;
    logic div_en;
    logic fin;
  } lane_ctl_t;

  typedef struct packed {
    logic [1:0]      ntri;
    vert_t [3:0]     v;
  } lane_res_t;

  // Tetrahedra as corner ids (X*4 + Y*2 + Z), even parity split first.
  localparam logic [2:0] SPLIT_TAB [2][5][4] = '{
    '{'{3'd3, 3'd2, 3'd0, 3'd6}, '{3'd5, 3'd4, 3'd6, 3'd0}, '{3'd0, 3'd1, 3'd3, 3'd5},
      '{3'd6, 3'd7, 3'd5, 3'd3}, '{3'd3, 3'd0, 3'd5, 3'd6}},
    '{'{3'd1, 3'd0, 3'd4, 3'd2}, '{3'd7, 3'd6, 3'd2, 3'd4}, '{3'd4, 3'd5, 3'd1, 3'd7},
      '{3'd2, 3'd3, 3'd7, 3'd1}, '{3'd1, 3'd2, 3'd4, 3'd7}}
  };

  // Edge end points as positions within the tetrahedron.
  localparam logic [1:0] EDGE_P [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd3};
  localparam logic [1:0] EDGE_Q [6] = '{2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2};

  // Triangles per case.
  localparam logic [1:0] CASE_NTRI [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
  };

  // Crossed edges per case, in vertex order.
  localparam logic [2:0] CASE_EDGE [16][4] = '{
    '{3'd0, 3'd0, 3'd0, 3'd0}, '{3'd0, 3'd2, 3'd1, 3'd0},
    '{3'd0, 3'd4, 3'd3, 3'd0}, '{3'd2, 3'd1, 3'd4, 3'd3},
    '{3'd1, 3'd5, 3'd4, 3'd0}, '{3'd2, 3'd5, 3'd4, 3'd0},
    '{3'd0, 3'd1, 3'd5, 3'd3}, '{3'd2, 3'd5, 3'd3, 3'd0},
    '{3'd2, 3'd3, 3'd5, 3'd0}, '{3'd1, 3'd0, 3'd3, 3'd5},
    '{3'd0, 3'd4, 3'd5, 3'd2}, '{3'd1, 3'd4, 3'd5, 3'd0},
    '{3'd1, 3'd2, 3'd3, 3'd4}, '{3'd0, 3'd3, 3'd4, 3'd0},
    '{3'd0, 3'd1, 3'd2, 3'd0}, '{3'd0, 3'd0, 3'd0, 3'd0}
  };

endpackage

[hw/rtl/mtc_lane.sv]
`timescale 1ns / 1ps
module mtc_lane import mtc_pkg::*; (
  input  logic        clk,
  input  lane_ctl_t   ctl,
  input  logic [15:0] threshold,
  input  logic [15:0] voxel_size,
  input  logic [7:0]  smp [NUM_SLOT],
  input  logic [2:0]  cid [NUM_SLOT],
  input  logic [23:0] pos_lo [3],
  input  logic [23:0] pos_hi [3],
  output lane_res_t   res
);

  logic [15:0] n_r  [NUM_SLOT];
  logic [15:0] d_r  [NUM_SLOT];
  logic [2:0]  cp_r [NUM_SLOT];
  logic [2:0]  cq_r [NUM_SLOT];
  logic [17:0] rem  [NUM_SLOT];
  logic [15:0] qr   [NUM_SLOT];

  logic [3:0]  idx;
  logic [15:0] n_c  [NUM_SLOT];
  logic [15:0] d_c  [NUM_SLOT];
  logic [2:0]  cp_c [NUM_SLOT];
  logic [2:0]  cq_c [NUM_SLOT];
  logic [17:0] rem_next [NUM_SLOT];
  logic [15:0] qr_next  [NUM_SLOT];
  logic [33:0] num_c    [NUM_SLOT];
  vert_t       vert_c   [NUM_SLOT];

  // Case index and the distance terms of each crossed edge.
  always_comb begin
    logic [2:0]  e;
    logic [1:0]  pp;
    logic [1:0]  pq;
    logic [16:0] dn;
    logic [16:0] dd;
    for (int i = 0; i < NUM_SLOT; i++) begin
      idx[i] = {smp[i], 8'h00} > threshold;
    end
    for (int k = 0; k < NUM_SLOT; k++) begin
      e  = CASE_EDGE[idx][k];
      pp = EDGE_P[e];
      pq = EDGE_Q[e];
      dn = {1'b0, threshold} - {1'b0, smp[pp], 8'h00};
      dd = {1'b0, smp[pq], 8'h00} - {1'b0, smp[pp], 8'h00};
      if (dd[16]) begin
        dn = -dn;
        dd = -dd;
      end
      if (dn[16]) begin
        n_c[k] = 16'd0;
      end else if (dn[15:0] > dd[15:0]) begin
        n_c[k] = dd[15:0];
      end else begin
        n_c[k] = dn[15:0];
      end
      d_c[k]  = dd[15:0];
      cp_c[k] = cid[pp];
      cq_c[k] = cid[pq];
    end
  end

  // Dividend 2*n*voxel + d, then two restoring steps of the divider.
  always_comb begin
    logic [31:0] prod;
    logic [17:0] r;
    logic [15:0] q;
    logic [17:0] dv;
    for (int k = 0; k < NUM_SLOT; k++) begin
      prod     = n_r[k] * voxel_size;
      num_c[k] = {1'b0, prod, 1'b0} + {18'd0, d_r[k]};
      dv = {1'b0, d_r[k], 1'b0};
      r  = rem[k];
      q  = qr[k];
      for (int s = 0; s < 2; s++) begin
        r = {r[16:0], q[15]};
        q = {q[14:0], 1'b0};
        if (r >= dv) begin
          r    = r - dv;
          q[0] = 1'b1;
        end
      end
      rem_next[k] = r;
      qr_next[k]  = q;
    end
  end

  // Vertex position: step from the first corner towards the second.
  always_comb begin
    logic [23:0] q24;
    logic [23:0] pa;
    logic [23:0] crd [3];
    logic        bp;
    logic        bq;
    for (int k = 0; k < NUM_SLOT; k++) begin
      q24 = (d_r[k] == 16'd0) ? 24'd0 : {8'd0, qr[k]};
      for (int ax = 0; ax < 3; ax++) begin
        bp = cp_r[k][2 - ax];
        bq = cq_r[k][2 - ax];
        pa = bp ? pos_hi[ax] : pos_lo[ax];
        if (bp == bq) begin
          crd[ax] = pa;
        end else if (bq) begin
          crd[ax] = pa + q24;
        end else begin
          crd[ax] = pa - q24;
        end
      end
      vert_c[k] = '{x: crd[0], y: crd[1], z: crd[2]};
    end
  end

  // Per-slot registers across the steps.
  always_ff @(posedge clk) begin
    if (ctl.ld_case) begin
      res.ntri <= CASE_NTRI[idx];
    end
    for (int k = 0; k < NUM_SLOT; k++) begin
      if (ctl.ld_case) begin
        n_r[k]  <= n_c[k];
        d_r[k]  <= d_c[k];
        cp_r[k] <= cp_c[k];
        cq_r[k] <= cq_c[k];
      end
      if (ctl.ld_mul) begin
        rem[k] <= num_c[k][33:16];
        qr[k]  <= num_c[k][15:0];
      end else if (ctl.div_en) begin
        rem[k] <= rem_next[k];
        qr[k]  <= qr_next[k];
      end
      if (ctl.fin) begin
        res.v[k] <= vert_c[k];
      end
    end
  end

endmodule

[hw/rtl/mtc_merge.sv]
`timescale 1ns / 1ps
module mtc_merge import mtc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  lane_res_t res [NUM_TETRA],
  output logic      free,
  input  logic      out_ready,
  output logic      out_valid,
  output vert_t     p0,
  output vert_t     p1,
  output vert_t     p2,
  output logic      last_of_cell
);

  lane_res_t  hold_r [NUM_TETRA];
  logic       active;
  logic [2:0] ptr;
  logic       sub;

  logic [NUM_TETRA-1:0] has;
  logic [NUM_TETRA-1:0] has_in;
  logic       nxt_found;
  logic [2:0] nxt_ptr;
  logic [2:0] first_ptr;
  lane_res_t  cur;
  logic       two;
  logic       emit;

  assign free = !active;

  // Next tetrahedron with triangles after the current one, and the first at load.
  always_comb begin
    nxt_found = 1'b0;
    nxt_ptr   = ptr;
    first_ptr = 3'd0;
    for (int j = NUM_TETRA - 1; j >= 0; j--) begin
      has[j]    = hold_r[j].ntri != 2'd0;
      has_in[j] = res[j].ntri != 2'd0;
      if (3'(j) > ptr && has[j]) begin
        nxt_found = 1'b1;
        nxt_ptr   = 3'(j);
      end
      if (has_in[j]) begin
        first_ptr = 3'(j);
      end
    end
  end

  assign cur  = hold_r[ptr];
  assign two  = cur.ntri == 2'd2;
  assign emit = active && (!out_valid || out_ready);

  // Walk the held triangles into the output register, one per cycle unless stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      ptr       <= 3'd0;
      sub       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        hold_r <= res;
        active <= |has_in;
        ptr    <= first_ptr;
        sub    <= 1'b0;
      end else if (emit) begin
        if (!sub && two) begin
          sub <= 1'b1;
        end else if (nxt_found) begin
          ptr <= nxt_ptr;
          sub <= 1'b0;
        end else begin
          active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      p0           <= cur.v[0];
      p1           <= sub ? cur.v[2] : cur.v[1];
      p2           <= sub ? cur.v[3] : cur.v[2];
      last_of_cell <= !(!sub && two) && !nxt_found;
    end
  end

endmodule

[hw/rtl/marching_tetrahedra_cube_top.sv]
// Marching tetrahedra over one grid cell. Each input item is a cell with its
// eight corner samples; each output item is one triangle, with last_of_cell set
// on the final triangle of that cell, and an empty cell gives no output at all.
// Five tetrahedron lanes work in parallel through a sequence of case lookup,
// one multiply, a two-bit-per-cycle divider for the edge interpolation, the
// position step and the hand-over to the merge buffer. A new cell is taken at
// the hand-over while the previous cell's triangles leave at one per cycle
// from that buffer; a cell gives at most ten triangles, so the buffer is free
// again before the next hand-over and only output stalls slow the block further.
// The user must write configuration only while idle; the block does not check.
`timescale 1ns / 1ps
`include "marching_tetrahedra_cube_top_macros.svh"
module marching_tetrahedra_cube_top import mtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  cell_x,
  input  logic [7:0]  cell_y,
  input  logic [7:0]  cell_z,
  input  logic [7:0]  corner_000,
  input  logic [7:0]  corner_001,
  input  logic [7:0]  corner_010,
  input  logic [7:0]  corner_011,
  input  logic [7:0]  corner_100,
  input  logic [7:0]  corner_101,
  input  logic [7:0]  corner_110,
  input  logic [7:0]  corner_111,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] p0_x,
  output logic [23:0] p0_y,
  output logic [23:0] p0_z,
  output logic [23:0] p1_x,
  output logic [23:0] p1_y,
  output logic [23:0] p1_z,
  output logic [23:0] p2_x,
  output logic [23:0] p2_y,
  output logic [23:0] p2_z,
  output logic        last_of_cell
);

  logic [15:0] threshold;
  logic [15:0] voxel_size;
  logic        busy;
  step_t       step;
  logic        accept;
  logic        load;
  logic        merge_free;
  lane_ctl_t   ctl;

  logic [7:0]  smp_r [8];
  logic        par_r;
  logic [23:0] pos_lo [3];
  logic [23:0] pos_hi [3];
  logic [7:0]  cell_in [3];

  logic [7:0]  lane_smp [NUM_TETRA][NUM_SLOT];
  logic [2:0]  lane_cid [NUM_TETRA][NUM_SLOT];
  lane_res_t   lane_res [NUM_TETRA];
  vert_t       tri_p0;
  vert_t       tri_p1;
  vert_t       tri_p2;

  assign cell_in[0] = cell_x;
  assign cell_in[1] = cell_y;
  assign cell_in[2] = cell_z;

  // Handshake and lane sequencing.
  assign accept   = in_valid && in_ready;
  assign load     = busy && (step == STEP_DONE) && merge_free;
  assign in_ready = !busy || ((step == STEP_DONE) && merge_free);

  assign ctl.ld_case = busy && (step == STEP_CASE);
  assign ctl.ld_mul  = busy && (step == STEP_MUL);
  assign ctl.div_en  = busy && (step >= STEP_DIV_FIRST) && (step <= STEP_DIV_LAST);
  assign ctl.fin     = busy && (step == STEP_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DONE;
    end else if (accept) begin
      busy <= 1'b1;
      step <= STEP_CASE;
    end else if (load) begin
      busy <= 1'b0;
    end else if (busy && (step != STEP_DONE)) begin
      step <= step + 4'd1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      voxel_size <= VOXEL_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data;
        REG_VOXEL_SIZE: voxel_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the cell: samples, parity and the corner positions on each axis.
  always_ff @(posedge clk) begin
    logic [24:0] lo;
    logic [24:0] hi;
    if (accept) begin
      smp_r[0] <= corner_000;
      smp_r[1] <= corner_001;
      smp_r[2] <= corner_010;
      smp_r[3] <= corner_011;
      smp_r[4] <= corner_100;
      smp_r[5] <= corner_101;
      smp_r[6] <= corner_110;
      smp_r[7] <= corner_111;
      par_r    <= cell_x[0] ^ cell_y[0] ^ cell_z[0];
      for (int ax = 0; ax < 3; ax++) begin
        lo = voxel_size * {1'b0, cell_in[ax]};
        hi = voxel_size * ({1'b0, cell_in[ax]} + 9'd1);
        pos_lo[ax] <= lo[23:0];
        pos_hi[ax] <= hi[23:0];
      end
    end
  end

  // One lane per tetrahedron of the split.
  for (genvar t = 0; t < NUM_TETRA; t++) begin : g_lane
    always_comb begin
      for (int i = 0; i < NUM_SLOT; i++) begin
        lane_cid[t][i] = par_r ? SPLIT_TAB[1][t][i] : SPLIT_TAB[0][t][i];
        lane_smp[t][i] = par_r ? smp_r[SPLIT_TAB[1][t][i]] : smp_r[SPLIT_TAB[0][t][i]];
      end
    end

    mtc_lane u_lane (
      .clk        (clk),
      .ctl        (ctl),
      .threshold  (threshold),
      .voxel_size (voxel_size),
      .smp        (lane_smp[t]),
      .cid        (lane_cid[t]),
      .pos_lo     (pos_lo),
      .pos_hi     (pos_hi),
      .res        (lane_res[t])
    );
  end

  // Merge the lanes' triangles into the output stream.
  mtc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .res          (lane_res),
    .free         (merge_free),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .p0           (tri_p0),
    .p1           (tri_p1),
    .p2           (tri_p2),
    .last_of_cell (last_of_cell)
  );

  assign p0_x = tri_p0.x;
  assign p0_y = tri_p0.y;
  assign p0_z = tri_p0.z;
  assign p1_x = tri_p1.x;
  assign p1_y = tri_p1.y;
  assign p1_z = tri_p1.z;
  assign p2_x = tri_p2.x;
  assign p2_y = tri_p2.y;
  assign p2_z = tri_p2.z;

  // An accepted item starts the lane sequence at the case step.
  `MTC_ASSERT_NXT(a_accept_starts, clk, rst, accept, busy && (step == STEP_CASE))
  // The sequence advances by one step every cycle until done.
  `MTC_ASSERT_NXT(a_step_advances, clk, rst, busy && (step != STEP_DONE), step == $past(step) + 4'd1)
  // Handing results to the merge frees the lanes unless a new item came in.
  `MTC_ASSERT_NXT(a_load_frees, clk, rst, load && !accept, !busy)
  // Nothing is taken while the lanes are mid-sequence.
  `MTC_ASSERT_IMP(a_no_accept_midway, clk, rst, busy && (step != STEP_DONE), !in_ready)

endmodule
